### src/prt_pkg.sv
// Package with the shared constants and types of the pending request retry tracker.
`default_nettype none
package prt_pkg;
  localparam int TableDepth = 16;
  localparam int SlotW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CntW = $clog2(TableDepth + 1);

  localparam logic [2:0] KIND_REGISTER = 3'd0;
  localparam logic [2:0] KIND_SUCCESS  = 3'd1;
  localparam logic [2:0] KIND_FAILURE  = 3'd2;
  localparam logic [2:0] KIND_ERROR    = 3'd3;
  localparam logic [2:0] KIND_TICK     = 3'd4;
  localparam logic [2:0] KIND_CANCEL   = 3'd5;
  localparam logic [2:0] KIND_CLEAR    = 3'd6;

  localparam logic [3:0] EV_REGISTERED = 4'd0;
  localparam logic [3:0] EV_INVALID    = 4'd1;
  localparam logic [3:0] EV_FULL       = 4'd2;
  localparam logic [3:0] EV_SUCCESS    = 4'd3;
  localparam logic [3:0] EV_FAILURE    = 4'd4;
  localparam logic [3:0] EV_ERROR      = 4'd5;
  localparam logic [3:0] EV_UNMATCHED  = 4'd6;
  localparam logic [3:0] EV_TIMEOUT    = 4'd7;
  localparam logic [3:0] EV_RETRANSMIT = 4'd8;
  localparam logic [3:0] EV_CANCELLED  = 4'd9;
  localparam logic [3:0] EV_NOT_FOUND  = 4'd10;
  localparam logic [3:0] EV_DONE       = 4'd11;

  localparam logic [0:0] REG_INTERVAL = 1'd0;
  localparam logic [0:0] REG_LIMIT    = 1'd1;

  // One result word.
  typedef struct packed {
    logic [3:0]  res;
    logic [31:0] id;
    logic [3:0]  retries;
    logic        last;
  } event_t;

  // One table entry as held in the memory.
  typedef struct packed {
    logic        retx_off;
    logic [3:0]  retries;
    logic [31:0] sent_time;
  } entry_t;
endpackage
`default_nettype wire

### src/pending_request_retry_tracker.sv
// Top level of the pending request retry tracker.
// The input channel takes one word per request event: register, reply,
// cancel, clear or tick. The result channel returns event words; the last
// word caused by an input word carries out_last_of_run.
// Register, clear, unmatched replies and unmatched cancels give their result in
// the cycle after acceptance. Matched replies and cancels read the entry memory
// first. A tick walks all TableDepth slots (memory read, then evaluate and write
// back for each slot), then gives a done word. Kind 7 gives no result.
// A new word is accepted only once the previous one has finished and the
// output register is free; a stalled receiver holds the walk in place.
// Reset empties the table at once and loads the default interval and
// limit. The cfg_ port is APB-style and always ready; the user is to write
// it only while the block is idle, which the block itself does not enforce.
`default_nettype none
module pending_request_retry_tracker
  import prt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_kind,
  input  wire logic [31:0] in_request_id,
  input  wire logic        in_skip_retransmit,
  input  wire logic [31:0] in_now_time,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [3:0]  out_event_res,
  output logic      [31:0] out_event_id,
  output logic      [3:0]  out_event_retries,
  output logic             out_last_of_run,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  logic [31:0] interval;
  logic [3:0]  limit;
  event_t      ev;

  prt_cfg u_cfg (
    .clk, .rst_n, .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite),
    .paddr(cfg_paddr), .pwdata(cfg_pwdata), .prdata(cfg_prdata),
    .pready(cfg_pready), .interval, .limit
  );

  prt_engine u_engine (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_request_id,
    .in_skip_retransmit, .in_now_time, .interval, .limit,
    .ev, .ev_valid(out_valid), .ev_ready(out_ready)
  );

  assign out_event_res     = ev.res;
  assign out_event_id      = ev.id;
  assign out_event_retries = ev.retries;
  assign out_last_of_run   = ev.last;
endmodule
`default_nettype wire

### src/prt_cfg.sv
// APB-style configuration registers of the tracker.
`default_nettype none
module prt_cfg
  import prt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output logic      [31:0] interval,
  output logic      [3:0]  limit
);
  logic [31:0] interval_r;
  logic [3:0]  limit_r;
  logic        wr;
  logic [0:0]  idx;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign idx = paddr[2];

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= 32'd10000;
      limit_r    <= 4'd5;
    end else if (wr && paddr[1:0] == 2'b00) begin
      unique case (idx)
        REG_INTERVAL: interval_r <= pwdata;
        REG_LIMIT:    limit_r    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read data.
  always_comb begin
    prdata = 32'd0;
    if (paddr[1:0] == 2'b00) begin
      unique case (idx)
        REG_INTERVAL: prdata = interval_r;
        REG_LIMIT:    prdata = {28'd0, limit_r};
        default: ;
      endcase
    end
  end

  assign interval = interval_r;
  assign limit    = limit_r;
endmodule
`default_nettype wire

### src/prt_engine.sv
// Sequencer with the id match table and the entry memory of the tracker.
`default_nettype none
module prt_engine
  import prt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_kind,
  input  wire logic [31:0] in_request_id,
  input  wire logic        in_skip_retransmit,
  input  wire logic [31:0] in_now_time,
  input  wire logic [31:0] interval,
  input  wire logic [3:0]  limit,
  output event_t           ev,
  output logic             ev_valid,
  input  wire logic        ev_ready
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [TableDepth-1:0] valid_r;
  logic [31:0]      ids_r [TableDepth];
  entry_t           mem [TableDepth];
  entry_t           rd_r;
  logic [2:0]       kind_r;
  logic [31:0]      now_r;
  logic [SlotW-1:0] slot_r;
  logic [CntW-1:0]  walk_r;
  event_t           ev_r;
  logic             ev_valid_r;
  logic             wr_en;
  logic [SlotW-1:0] wr_addr;
  entry_t           wr_data;
  logic [SlotW-1:0] rd_addr;
  logic             hit, has_free;
  logic [SlotW-1:0] hit_idx, free_idx;
  logic             accept, out_free;
  logic             due;
  logic [31:0]      age;

  assign out_free = !ev_valid_r || ev_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  // Id match and free slot search over the register table.
  always_comb begin
    hit = 1'b0; hit_idx = '0; has_free = 1'b0; free_idx = '0;
    for (int i = TableDepth - 1; i >= 0; i--) begin
      if (valid_r[i] && ids_r[i] == in_request_id) begin
        hit = 1'b1; hit_idx = SlotW'(i);
      end
      if (!valid_r[i]) begin
        has_free = 1'b1; free_idx = SlotW'(i);
      end
    end
    if (in_request_id == 32'd0) hit = 1'b0;
  end

  assign age = now_r - rd_r.sent_time;
  assign due = age > interval;
  // A tick starts its walk at slot zero, a lookup reads the matching slot.
  assign rd_addr = !accept ? slot_r : (in_kind == KIND_TICK) ? '0 : hit_idx;

  // Entry memory with one read and one write port.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[rd_addr];
  end

  always_comb begin
    wr_en = 1'b0; wr_addr = slot_r; wr_data = rd_r;
    if (accept && in_kind == KIND_REGISTER && in_request_id != 32'd0 && !hit && has_free) begin
      wr_en = 1'b1; wr_addr = free_idx;
      wr_data = '{retx_off: in_skip_retransmit, retries: 4'd0, sent_time: in_now_time};
    end else if (state_r == ST_WALK && out_free && walk_r != CntW'(TableDepth) &&
                 valid_r[slot_r] && due && !(rd_r.retries > limit)) begin
      wr_en = 1'b1;
      wr_data.sent_time = now_r;
      if (rd_r.retries != 4'hF) wr_data.retries = rd_r.retries + 4'd1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) begin
        case (in_kind)
          KIND_SUCCESS, KIND_FAILURE, KIND_ERROR, KIND_CANCEL:
            state_nxt = hit ? ST_READ : ST_IDLE;
          KIND_TICK: state_nxt = ST_WALK;
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_READ: if (out_free) state_nxt = ST_IDLE;
      ST_WALK: if (out_free) state_nxt = (walk_r == CntW'(TableDepth)) ? ST_IDLE : ST_EMIT;
      ST_EMIT: state_nxt = ST_WALK;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control, table and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; valid_r <= '0; ev_valid_r <= 1'b0;
      walk_r <= '0; slot_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (ev_valid_r && ev_ready) ev_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: if (accept) begin
          kind_r <= in_kind; now_r <= in_now_time; slot_r <= hit_idx;
          ev_r <= '{res: EV_DONE, id: in_request_id, retries: 4'd0, last: 1'b1};
          case (in_kind)
            KIND_REGISTER: begin
              ev_valid_r <= 1'b1;
              if (in_request_id == 32'd0 || hit) ev_r.res <= EV_INVALID;
              else if (!has_free) ev_r.res <= EV_FULL;
              else begin
                ev_r.res <= EV_REGISTERED;
                valid_r[free_idx] <= 1'b1;
                ids_r[free_idx] <= in_request_id;
              end
            end
            KIND_SUCCESS, KIND_FAILURE, KIND_ERROR: if (!hit) begin
              ev_valid_r <= 1'b1; ev_r.res <= EV_UNMATCHED;
            end
            KIND_CANCEL: if (!hit) begin
              ev_valid_r <= 1'b1; ev_r.res <= EV_NOT_FOUND;
            end
            KIND_CLEAR: begin
              ev_valid_r <= 1'b1; valid_r <= '0; ev_r.id <= 32'd0;
            end
            KIND_TICK: begin
              slot_r <= '0; walk_r <= '0;
            end
            default: ;
          endcase
        end
        ST_READ: if (out_free) begin
          ev_valid_r <= 1'b1;
          valid_r[slot_r] <= 1'b0;
          ev_r.retries <= rd_r.retries;
          ev_r.res <= (kind_r == KIND_CANCEL) ? EV_CANCELLED : EV_SUCCESS + {1'b0, kind_r} - 4'd1;
        end
        ST_WALK: if (out_free) begin
          // One slot per visit; the next slot is read from the memory in the following cycle.
          if (walk_r != CntW'(TableDepth)) begin
            walk_r <= walk_r + CntW'(1);
            if (walk_r + CntW'(1) != CntW'(TableDepth)) slot_r <= slot_r + SlotW'(1);
          end
          ev_r.id <= ids_r[slot_r]; ev_r.retries <= rd_r.retries; ev_r.last <= 1'b0;
          if (walk_r == CntW'(TableDepth)) begin
            ev_valid_r <= 1'b1;
            ev_r <= '{res: EV_DONE, id: 32'd0, retries: 4'd0, last: 1'b1};
          end else if (valid_r[slot_r] && due) begin
            if (rd_r.retries > limit) begin
              ev_valid_r <= 1'b1; ev_r.res <= EV_TIMEOUT; valid_r[slot_r] <= 1'b0;
            end else if (!rd_r.retx_off) begin
              ev_valid_r <= 1'b1; ev_r.res <= EV_RETRANSMIT;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign ev = ev_r;
  assign ev_valid = ev_valid_r;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == ST_IDLE) else $error("ready outside idle");
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    walk_r <= CntW'(TableDepth)) else $error("walk counter overrun");
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    ev_valid_r && ev_r.res == EV_DONE |-> ev_r.last) else $error("done not last");
endmodule
`default_nettype wire

### tb/sv/tb_pending_request_retry_tracker.sv
// Testbench for the pending request retry tracker with a self-checking request table model.
`default_nettype none
module tb_pending_request_retry_tracker;
  import prt_pkg::*;

  // Table model and store of expected event words.
  class retry_table_model;
    logic [31:0] interval;
    logic [3:0]  limit;
    bit          used [TableDepth];
    logic [31:0] ids [TableDepth];
    bit          retx_off [TableDepth];
    logic [3:0]  retries [TableDepth];
    logic [31:0] sent [TableDepth];
    event_t      expected_q [$];
    int          errors;

    function new();
      interval = 32'd10000;
      limit = 4'd5;
      errors = 0;
      foreach (used[i]) used[i] = 1'b0;
    endfunction

    function int find(logic [31:0] id);
      if (id == 32'd0) return -1;
      for (int i = 0; i < TableDepth; i++)
        if (used[i] && ids[i] == id) return i;
      return -1;
    endfunction

    function void push(logic [3:0] res, logic [31:0] id, logic [3:0] rt, logic last);
      event_t e;
      e.res = res;
      e.id = id;
      e.retries = rt;
      e.last = last;
      expected_q.push_back(e);
    endfunction

    // Work out the event words that one accepted word causes.
    function void note_input(logic [2:0] kind, logic [31:0] id, logic skip, logic [31:0] now);
      int s;
      s = find(id);
      case (kind)
        KIND_REGISTER: begin
          if (id == 32'd0 || s >= 0) begin
            push(EV_INVALID, id, 4'd0, 1'b1);
          end else begin
            s = -1;
            for (int i = 0; i < TableDepth; i++)
              if (!used[i] && s < 0) s = i;
            if (s < 0) begin
              push(EV_FULL, id, 4'd0, 1'b1);
            end else begin
              used[s] = 1'b1;
              ids[s] = id;
              retx_off[s] = skip;
              retries[s] = 4'd0;
              sent[s] = now;
              push(EV_REGISTERED, id, 4'd0, 1'b1);
            end
          end
        end
        KIND_SUCCESS, KIND_FAILURE, KIND_ERROR: begin
          if (s < 0) begin
            push(EV_UNMATCHED, id, 4'd0, 1'b1);
          end else begin
            used[s] = 1'b0;
            push(kind == KIND_SUCCESS ? EV_SUCCESS :
                 kind == KIND_FAILURE ? EV_FAILURE : EV_ERROR, id, retries[s], 1'b1);
          end
        end
        KIND_CANCEL: begin
          if (s < 0) begin
            push(EV_NOT_FOUND, id, 4'd0, 1'b1);
          end else begin
            used[s] = 1'b0;
            push(EV_CANCELLED, id, retries[s], 1'b1);
          end
        end
        KIND_TICK: begin
          for (int i = 0; i < TableDepth; i++) begin
            logic [31:0] age;
            age = now - sent[i];
            if (used[i] && age > interval) begin
              if (retries[i] > limit) begin
                push(EV_TIMEOUT, ids[i], retries[i], 1'b0);
                used[i] = 1'b0;
              end else begin
                if (!retx_off[i]) push(EV_RETRANSMIT, ids[i], retries[i], 1'b0);
                if (retries[i] != 4'd15) retries[i] = retries[i] + 4'd1;
                sent[i] = now;
              end
            end
          end
          push(EV_DONE, 32'd0, 4'd0, 1'b1);
        end
        KIND_CLEAR: begin
          foreach (used[i]) used[i] = 1'b0;
          push(EV_DONE, 32'd0, 4'd0, 1'b1);
        end
        default: ;
      endcase
    endfunction

    function void report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endfunction

    // Compare one received word with the oldest expected word.
    function void check_result(event_t got);
      event_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word res=%0d id=%h", got.res, got.id));
        return;
      end
      want = expected_q.pop_front();
      if (got.res !== want.res)
        report_mismatch($sformatf("event_res %0d, want %0d", got.res, want.res));
      if (got.id !== want.id)
        report_mismatch($sformatf("event_id %h, want %h", got.id, want.id));
      if (got.retries !== want.retries)
        report_mismatch($sformatf("event_retries %0d, want %0d", got.retries, want.retries));
      if (got.last !== want.last)
        report_mismatch($sformatf("last_of_run %0d, want %0d", got.last, want.last));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_kind = '0;
  logic [31:0] in_request_id = '0;
  logic        in_skip_retransmit = 1'b0;
  logic [31:0] in_now_time = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_event_res;
  logic [31:0] out_event_id;
  logic [3:0]  out_event_retries;
  logic        out_last_of_run;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  retry_table_model table_model = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  logic [31:0] clock_ms = '0;
  logic [31:0] id_pool [24];

  pending_request_retry_tracker i_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Check every accepted event word.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      table_model.check_result({out_event_res, out_event_id, out_event_retries,
                                out_last_of_run});
  end

  // Offer one word, with random idle cycles first, and wait for acceptance.
  task automatic send_word(logic [2:0] kind, logic [31:0] id, logic skip, logic [31:0] now);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_request_id <= id;
    in_skip_retransmit <= skip;
    in_now_time <= now;
    forever begin
      @(posedge clk);
      if (in_ready) break;
      @(negedge clk);
    end
    table_model.note_input(kind, id, skip, now);
    @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle.
  task automatic write_reg(logic [0:0] index, logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {index, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (index == REG_INTERVAL) table_model.interval = value;
    else table_model.limit = value[3:0];
  endtask

  // Wait until every expected word is back and a tick walk could have ended.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (table_model.expected_q.size() != 0) @(negedge clk);
    repeat (2 * TableDepth + 10) @(negedge clk);
  endtask

  // Random word: mostly ids from a small pool so the table fills and matches.
  task automatic send_random(int step_max);
    int k;
    logic [2:0]  kind;
    logic [31:0] id;
    logic [31:0] now;
    k = $urandom_range(0, 99);
    kind = k < 36 ? KIND_REGISTER : k < 44 ? KIND_SUCCESS : k < 51 ? KIND_FAILURE :
           k < 58 ? KIND_ERROR : k < 68 ? KIND_CANCEL : k < 94 ? KIND_TICK :
           k < 97 ? KIND_CLEAR : 3'd7;
    k = $urandom_range(0, 99);
    id = k < 75 ? id_pool[$urandom_range(0, 23)] : k < 95 ? $urandom : 32'd0;
    clock_ms = clock_ms + $urandom_range(0, step_max);
    now = ($urandom_range(0, 19) == 0) ? $urandom : clock_ms;
    send_word(kind, id, 1'($urandom_range(0, 1)), now);
  endtask

  task automatic run_phase(logic [31:0] interval, logic [3:0] limit, int step_max,
                           int s_idle, int r_idle, int count);
    wait_idle();
    write_reg(REG_INTERVAL, interval);
    write_reg(REG_LIMIT, limit);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    foreach (id_pool[i]) id_pool[i] = $urandom;
    id_pool[0] = 32'hFFFF_FFFF;
    id_pool[1] = 32'd1;
    repeat (count) send_random(step_max);
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words with the reset interval and limit.
    send_word(KIND_REGISTER, 32'd0, 1'b0, 32'd0);
    send_word(KIND_REGISTER, 32'hFFFF_FFFF, 1'b0, 32'd0);
    send_word(KIND_REGISTER, 32'hFFFF_FFFF, 1'b0, 32'd0);
    send_word(KIND_REGISTER, 32'd1, 1'b1, 32'd0);
    send_word(KIND_REGISTER, 32'h8000_0000, 1'b0, 32'd5);
    send_word(KIND_TICK, 32'd0, 1'b0, 32'd10000);
    send_word(KIND_TICK, 32'd0, 1'b0, 32'd10001);
    send_word(KIND_TICK, 32'd0, 1'b0, 32'hFFFF_FFF0);
    send_word(KIND_SUCCESS, 32'hFFFF_FFFF, 1'b0, 32'd0);
    send_word(KIND_FAILURE, 32'h8000_0000, 1'b0, 32'd0);
    send_word(KIND_ERROR, 32'd1, 1'b0, 32'd0);
    send_word(KIND_ERROR, 32'd1, 1'b0, 32'd0);
    send_word(KIND_SUCCESS, 32'd0, 1'b0, 32'd0);
    send_word(KIND_CANCEL, 32'd7, 1'b0, 32'd0);
    send_word(KIND_CANCEL, 32'd0, 1'b0, 32'd0);
    send_word(KIND_REGISTER, 32'd7, 1'b1, 32'hFFFF_FFFF);
    send_word(KIND_CANCEL, 32'd7, 1'b0, 32'd0);
    send_word(KIND_REGISTER, 32'd9, 1'b0, 32'd3);
    send_word(KIND_CLEAR, 32'd0, 1'b0, 32'd0);
    send_word(3'd7, 32'd9, 1'b1, 32'hFFFF_FFFF);
    send_word(KIND_TICK, 32'd0, 1'b0, 32'd0);

    // Random phases; the first starts with a long receiver hold-off.
    hold_left = 400;
    run_phase(32'd200, 4'd0, 120, 25, 74, 80);
    run_phase(32'd1, 4'd14, 3, 74, 25, 80);
    run_phase(32'hFFFF_FFFF, 4'd15, 2000, 0, 0, 80);
    run_phase(32'd500, 4'd2, 300, 0, 0, 80);
    wait_idle();

    if (table_model.errors == 0 && table_model.expected_q.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
src/prt_pkg.sv
src/prt_cfg.sv
src/prt_engine.sv
src/pending_request_retry_tracker.sv
tb/sv/tb_pending_request_retry_tracker.sv
